>>> design/four_level_page_table_walker_defines.svh
// ----------------------------------------------------------------------------
// Four-level page table walker: assertion macros
// Shared helpers for the concurrent checks, clocked on clk, off in reset.
// ----------------------------------------------------------------------------
`ifndef FOUR_LEVEL_PAGE_TABLE_WALKER_DEFINES_SVH
`define FOUR_LEVEL_PAGE_TABLE_WALKER_DEFINES_SVH

// Consequent holds in the same cycle as the antecedent.
`define PTW_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("page table walker check failed");

// Consequent holds in the cycle after the antecedent.
`define PTW_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("page table walker check failed");

`endif

>>> design/ptw_pkg.sv
// ----------------------------------------------------------------------------
// Page table walker package
// Memory geometry, operation codes and the address unit's result type.
// ----------------------------------------------------------------------------
package ptw_pkg;

  localparam int MEM_WORDS = 4096;
  localparam int MEM_AW    = $clog2(MEM_WORDS);

  localparam int          PAGE_BITS  = 12;
  localparam int          INDEX_BITS = 9;
  localparam logic [63:0] PAGE_MASK  = 64'hfff;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_XLATE = 1'b1;

  typedef struct packed {
    logic              fault;
    logic [MEM_AW-1:0] word_addr;
  } ptw_addr_t;

endpackage

>>> design/ptw_addr.sv
// ----------------------------------------------------------------------------
// Page table walker: entry address unit
// Picks the level's nine-bit index, forms the table word address and flags
// a table word that lies outside the memory window.
// ----------------------------------------------------------------------------
module ptw_addr
  import ptw_pkg::*;
(
  input  logic [63:0] table_base,
  input  logic [47:0] virtual_address,
  input  logic [1:0]  level,
  output ptw_addr_t   entry
);

  logic [INDEX_BITS-1:0] idx;
  logic [60:0]           word;

  always_comb begin
    unique case (level)
      2'd3: idx = virtual_address[47:39];
      2'd2: idx = virtual_address[38:30];
      2'd1: idx = virtual_address[29:21];
      2'd0: idx = virtual_address[20:12];
      default: idx = '0;
    endcase
  end

  // Table base is page aligned, so adding the index is an OR.
  assign word = table_base[63:3] | 61'(idx);

  assign entry.fault     = (word >= 61'(MEM_WORDS));
  assign entry.word_addr = word[MEM_AW-1:0];

endmodule

>>> design/four_level_page_table_walker.sv
// ----------------------------------------------------------------------------
// Four-level page table walker
// Translates 48-bit virtual addresses through tables in an internal memory.
// ----------------------------------------------------------------------------
// A translation makes four dependent reads of the single table memory, with
// the result registered as the last entry is checked. A walk that stops
// early on a missing entry or a window fault finishes sooner. A table write
// gives no result. After reset the block sweeps the table memory to zero,
// one word a cycle, through all MEM_WORDS (4096) words before it takes the
// first word; the root register can be written meanwhile.
// ----------------------------------------------------------------------------
module four_level_page_table_walker
  import ptw_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,

  input  logic        cfg_wr_en,
  input  logic [14:0] cfg_wr_data,

  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_operation,
  input  logic [47:0] in_virtual_address,
  input  logic [11:0] in_word_index,
  input  logic [63:0] in_word_data,

  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_mapped,
  output logic [63:0] out_physical_address,
  output logic        out_window_fault
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_WALK  = 2'd1;
  localparam logic [1:0] ST_FAULT = 2'd2;

  logic [1:0]        state_r, state_nxt;
  logic [1:0]        level_r, level_nxt;
  logic [47:0]       va_r, va_nxt;
  logic [14:0]       root_r;
  logic              clearing_r;
  logic [MEM_AW-1:0] clr_addr_r;

  logic [63:0]       mem [MEM_WORDS];
  logic [63:0]       rdata_r;
  logic              mem_re, mem_we;
  logic [MEM_AW-1:0] mem_waddr;
  logic [63:0]       mem_wdata;

  logic [63:0]       au_base;
  logic [47:0]       au_va;
  logic [1:0]        au_level;
  ptw_addr_t         au_entry;

  logic              in_fire, slot_free, emit;
  logic              res_mapped, res_wf;
  logic [63:0]       res_pa;

  logic              out_valid_r, out_valid_nxt;
  logic              out_mapped_r, out_wf_r;
  logic [63:0]       out_pa_r;

  assign in_ready  = (state_r == ST_IDLE) && !clearing_r;
  assign in_fire   = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;

  // Root table on acceptance, entry just read while walking.
  assign au_base  = (state_r == ST_WALK) ? (rdata_r & ~PAGE_MASK)
                                         : (64'(root_r) & ~PAGE_MASK);
  assign au_va    = (state_r == ST_WALK) ? va_r : in_virtual_address;
  assign au_level = (state_r == ST_WALK) ? (level_r - 2'd1) : 2'd3;

  ptw_addr u_addr (
    .table_base      (au_base),
    .virtual_address (au_va),
    .level           (au_level),
    .entry           (au_entry)
  );

  assign mem_we    = clearing_r ||
                     (in_fire && (in_operation == OP_WRITE) &&
                      (32'(in_word_index) < 32'(MEM_WORDS)));
  assign mem_waddr = clearing_r ? clr_addr_r : MEM_AW'(in_word_index);
  assign mem_wdata = clearing_r ? 64'd0 : in_word_data;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_r <= mem[au_entry.word_addr];
    end
  end

  always_comb begin
    state_nxt  = state_r;
    level_nxt  = level_r;
    va_nxt     = va_r;
    mem_re     = 1'b0;
    emit       = 1'b0;
    res_mapped = 1'b0;
    res_wf     = 1'b0;
    res_pa     = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire && (in_operation == OP_XLATE)) begin
          va_nxt    = in_virtual_address;
          level_nxt = 2'd3;
          if (au_entry.fault) begin
            state_nxt = ST_FAULT;
          end else begin
            mem_re    = 1'b1;
            state_nxt = ST_WALK;
          end
        end
      end
      ST_WALK: begin
        // Read data holds while a result waits for a free output slot.
        priority if (!rdata_r[0]) begin
          if (slot_free) begin
            emit      = 1'b1;
            state_nxt = ST_IDLE;
          end
        end else if (level_r == 2'd0) begin
          res_mapped = 1'b1;
          res_pa     = (rdata_r & ~PAGE_MASK) | 64'(va_r[PAGE_BITS-1:0]);
          if (slot_free) begin
            emit      = 1'b1;
            state_nxt = ST_IDLE;
          end
        end else if (au_entry.fault) begin
          res_wf = 1'b1;
          if (slot_free) begin
            emit      = 1'b1;
            state_nxt = ST_IDLE;
          end
        end else begin
          mem_re    = 1'b1;
          level_nxt = level_r - 2'd1;
        end
      end
      ST_FAULT: begin
        res_wf = 1'b1;
        if (slot_free) begin
          emit      = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_valid_nxt = emit || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      root_r      <= '0;
      clearing_r  <= 1'b1;
      clr_addr_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        root_r <= cfg_wr_data;
      end
      if (clearing_r) begin
        clr_addr_r <= clr_addr_r + MEM_AW'(1);
        if (clr_addr_r == MEM_AW'(MEM_WORDS - 1)) begin
          clearing_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    level_r <= level_nxt;
    va_r    <= va_nxt;
    if (emit) begin
      out_mapped_r <= res_mapped;
      out_pa_r     <= res_pa;
      out_wf_r     <= res_wf;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_mapped           = out_mapped_r;
  assign out_physical_address = out_pa_r;
  assign out_window_fault     = out_wf_r;

endmodule

>>> design/ptw_checker.sv
// ----------------------------------------------------------------------------
// Page table walker port checker
// Watches the walker's ports for result consistency and busy behavior.
// ----------------------------------------------------------------------------
`include "four_level_page_table_walker_defines.svh"

module ptw_checker
  import ptw_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_operation,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_mapped,
  input logic [63:0] out_physical_address,
  input logic        out_window_fault
);

  logic xlate_accept;

  assign xlate_accept = in_valid && in_ready && (in_operation == OP_XLATE);

  // Hold a stalled result word.
  `PTW_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_physical_address))
  `PTW_ASSERT_NOW(a_unmapped_zero, out_valid && !out_mapped, out_physical_address == 64'd0)
  `PTW_ASSERT_NOW(a_fault_unmapped, out_valid && out_window_fault, !out_mapped)
  // A translation keeps the block busy once it is accepted.
  `PTW_ASSERT_NEXT(a_walk_busy, xlate_accept, !in_ready)

endmodule

bind four_level_page_table_walker ptw_checker u_ptw_checker (.*);
